@@ hdl/mvna_pkg.sv @@
// Shared types and constants for the mesh vertex normal accumulator.
// No dependencies; imported by mvna_norm, the top level and the testbench.
package mvna_pkg;

    localparam int VERTEX_DEPTH = 256;
    localparam int VIDX_W       = $clog2(VERTEX_DEPTH);
    localparam int IDX_W        = 8;     // width of the corner and read_index ports
    localparam int POS_W        = 20;    // Q10.10 position component
    localparam int EDGE_W       = POS_W + 1;
    localparam int PROD_W       = 2 * EDGE_W;
    localparam int VEC_W        = PROD_W + 1;   // cross product component
    localparam int NRM_W        = 16;    // Q1.14 normal component
    localparam int FRAC_W       = 14;
    localparam int SCL_W        = 30;    // magnitude after scaling, below 2^30
    localparam int SQ_W         = 2 * SCL_W;
    localparam int LEN_W        = SQ_W + 2;
    localparam int ISQ_W        = LEN_W + 1;
    localparam int RT_W         = 31;    // floor(sqrt(len)) lies below 2^31
    localparam int Q_W          = 15;    // quotient never exceeds 16384
    localparam int NUM_W        = SCL_W + FRAC_W + 1;
    localparam int REM_W        = RT_W;
    localparam int CNT_W        = 5;
    localparam int ROOT_STEPS   = ISQ_W / 2 + 1;
    localparam int POS_ENTRY_W  = 3 * POS_W;
    localparam int NRM_ENTRY_W  = 3 * NRM_W;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TRI   = 2'd1,
        OP_READ  = 2'd2,
        OP_SPARE = 2'd3     // unused, ignored
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_RD_CAP,
        ST_PA,
        ST_PB,
        ST_PC,
        ST_PCAP,
        ST_CROSS,
        ST_FACE_GO,
        ST_FACE_WAIT,
        ST_CRN_RD,
        ST_CRN_GO,
        ST_CRN_WAIT
    } top_state_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_ROOT,
        N_DLOAD,
        N_DIV,
        N_DONE
    } norm_state_t;

endpackage

@@ hdl/mvna_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mvna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/mvna_norm.sv @@
// Iterative vector normalizer: scale, sum of squares, bit-serial square root,
// and three parallel restoring divisions. Depends on mvna_pkg.
module mvna_norm (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [mvna_pkg::VEC_W-1:0]   vec [3],
    output logic                                done,
    output logic signed [mvna_pkg::NRM_W-1:0]   res [3]
);
    import mvna_pkg::*;

    norm_state_t state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VEC_W-1:0]  mag_reg [3];
    logic [VEC_W-1:0]  mag_next [3];
    logic              neg_reg [3];
    logic              neg_next [3];
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  sx_reg, sx_next;
    logic [ISQ_W-1:0]  sr_reg, sr_next;
    logic [ISQ_W-1:0]  bit_reg, bit_next;
    logic [RT_W-1:0]   root_reg, root_next;
    logic [REM_W-1:0]  rem_reg [3];
    logic [REM_W-1:0]  rem_next [3];
    logic [Q_W-1:0]    dvd_reg [3];
    logic [Q_W-1:0]    dvd_next [3];
    logic [Q_W-1:0]    q_reg [3];
    logic [Q_W-1:0]    q_next [3];

    logic              too_big;
    logic              too_small;
    logic              all_zero;
    logic [SCL_W-1:0]  sq_op;
    logic [ISQ_W-1:0]  root_try;
    logic [NUM_W-1:0]  num [3];
    logic [REM_W:0]    dtry [3];
    logic [RT_W-1:0]   root_now;

    always_comb
    begin
        too_big   = 1'b0;
        too_small = 1'b1;
        all_zero  = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            too_big   = too_big | (|mag_reg[i][VEC_W-1:SCL_W]);
            too_small = too_small & ~(|mag_reg[i][VEC_W-1:SCL_W-1]);
            all_zero  = all_zero & (vec[i] == '0);
        end
    end

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    sq_op = mag_reg[0][SCL_W-1:0];
            2'd1:    sq_op = mag_reg[1][SCL_W-1:0];
            default: sq_op = mag_reg[2][SCL_W-1:0];
        endcase
    end

    assign root_try = sr_reg + bit_reg;
    assign root_now = sr_reg[RT_W-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num[i]  = {1'b0, mag_reg[i][SCL_W-1:0], FRAC_W'(0)}
                      + NUM_W'(root_now >> 1);
            dtry[i] = {rem_reg[i], dvd_reg[i][Q_W-1]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sq_next    = sq_reg;
        len_next   = len_reg;
        sx_next    = sx_reg;
        sr_next    = sr_reg;
        bit_next   = bit_reg;
        root_next  = root_reg;
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = mag_reg[i];
            neg_next[i] = neg_reg[i];
            rem_next[i] = rem_reg[i];
            dvd_next[i] = dvd_reg[i];
            q_next[i]   = q_reg[i];
        end
        done = 1'b0;

        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_next[i] = vec[i][VEC_W-1];
                        mag_next[i] = vec[i][VEC_W-1] ? VEC_W'(-vec[i]) : VEC_W'(vec[i]);
                        q_next[i]   = '0;
                    end
                    state_next = all_zero ? N_DONE : N_SHIFT;
                end
            end
            N_SHIFT:
            begin
                if (too_big)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
                else if (too_small)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                end
                else
                begin
                    cnt_next   = '0;
                    len_next   = '0;
                    state_next = N_SQ;
                end
            end
            N_SQ:
            begin
                // square here into sq_reg, then accumulate the registered square into len
                sq_next = SQ_W'(sq_op * sq_op);
                if (cnt_reg != '0)
                begin
                    len_next = len_reg + LEN_W'(sq_reg);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(3))
                begin
                    sx_next    = len_reg + LEN_W'(sq_reg);
                    sr_next    = '0;
                    bit_next   = ISQ_W'(1) << (ISQ_W - 1);
                    cnt_next   = '0;
                    state_next = N_ROOT;
                end
            end
            N_ROOT:
            begin
                if (ISQ_W'(sx_reg) >= root_try)
                begin
                    sx_next = LEN_W'(ISQ_W'(sx_reg) - root_try);
                    sr_next = (sr_reg >> 1) + bit_reg;
                end
                else
                begin
                    sr_next = sr_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                begin
                    state_next = N_DLOAD;
                end
            end
            N_DLOAD:
            begin
                root_next = root_now;
                for (int i = 0; i < 3; i++)
                begin
                    rem_next[i] = REM_W'(num[i][NUM_W-1:Q_W]);
                    dvd_next[i] = num[i][Q_W-1:0];
                    q_next[i]   = '0;
                end
                cnt_next   = '0;
                state_next = N_DIV;
            end
            N_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (dtry[i] >= (REM_W + 1)'(root_reg))
                    begin
                        rem_next[i] = REM_W'(dtry[i] - (REM_W + 1)'(root_reg));
                        q_next[i]   = {q_reg[i][Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[i] = REM_W'(dtry[i]);
                        q_next[i]   = {q_reg[i][Q_W-2:0], 1'b0};
                    end
                    dvd_next[i] = dvd_reg[i] << 1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(Q_W - 1))
                begin
                    state_next = N_DONE;
                end
            end
            N_DONE:
            begin
                done       = 1'b1;
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            res[i] = neg_reg[i] ? -$signed({1'b0, q_reg[i]}) : $signed({1'b0, q_reg[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= sq_next;
        len_reg  <= len_next;
        sx_reg   <= sx_next;
        sr_reg   <= sr_next;
        bit_reg  <= bit_next;
        root_reg <= root_next;
        for (int i = 0; i < 3; i++)
        begin
            mag_reg[i] <= mag_next[i];
            neg_reg[i] <= neg_next[i];
            rem_reg[i] <= rem_next[i];
            dvd_reg[i] <= dvd_next[i];
            q_reg[i]   <= q_next[i];
        end
    end

    // a new vector is taken only by an idle unit
    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == N_IDLE))
        else $error("normalizer started while busy");

endmodule

@@ hdl/mesh_vertex_normal_accumulator.sv @@
// Top level of the mesh vertex normal accumulator: command sequencer,
// position and normal stores. Depends on mvna_pkg, mvna_ram and mvna_norm.
//
//  channel   handshake          payload
//  command   start / busy       opcode, corner_a, corner_b, corner_c, pos_x, pos_y, pos_z
//  result    strobe (1 cycle)   read_index, norm_x, norm_y, norm_z
//
// A position write is done in the accept cycle and keeps the unit idle; a
// normal read steps through ST_RD and ST_RD_CAP, then its registered result
// shows with the strobe. A triangle takes four passes of the shared iterative
// normalizer (scale, squares, root, divide, handoff), plus the store reads
// and the cross product; a zero vector skips straight to the done state.
// The normal store needs no clearing pass after reset: per-vertex
// valid bits, cleared by reset and by a position write, mask its reads.
// The result port has no back-pressure.
module mesh_vertex_normal_accumulator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          opcode,
    input  logic [mvna_pkg::IDX_W-1:0]          corner_a,
    input  logic [mvna_pkg::IDX_W-1:0]          corner_b,
    input  logic [mvna_pkg::IDX_W-1:0]          corner_c,
    input  logic signed [mvna_pkg::POS_W-1:0]   pos_x,
    input  logic signed [mvna_pkg::POS_W-1:0]   pos_y,
    input  logic signed [mvna_pkg::POS_W-1:0]   pos_z,
    output logic                                strobe,
    output logic [mvna_pkg::IDX_W-1:0]          read_index,
    output logic signed [mvna_pkg::NRM_W-1:0]   norm_x,
    output logic signed [mvna_pkg::NRM_W-1:0]   norm_y,
    output logic signed [mvna_pkg::NRM_W-1:0]   norm_z
);
    import mvna_pkg::*;

    top_state_t state_reg, state_next;
    logic                      strobe_reg;
    logic [2:0]                kc_reg, kc_next;
    logic [1:0]                crn_reg, crn_next;
    logic                      nvalid_reg [VERTEX_DEPTH];

    logic [VIDX_W-1:0]         a_reg, b_reg, c_reg;
    logic signed [POS_W-1:0]   pa_reg [3];
    logic signed [POS_W-1:0]   pb_reg [3];
    logic signed [EDGE_W-1:0]  e1_reg [3];
    logic signed [EDGE_W-1:0]  e2_reg [3];
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [VEC_W-1:0]   cr_reg [3];
    logic signed [NRM_W-1:0]   face_reg [3];
    logic [IDX_W-1:0]          read_index_reg;
    logic signed [NRM_W-1:0]   out_reg [3];

    logic                      accept;
    logic                      pos_we;
    logic [VIDX_W-1:0]         pos_raddr;
    logic [POS_ENTRY_W-1:0]    pos_rdata;
    logic                      nrm_we;
    logic [VIDX_W-1:0]         nrm_raddr;
    logic [NRM_ENTRY_W-1:0]    nrm_rdata;
    logic [NRM_ENTRY_W-1:0]    nrm_wdata;
    logic [VIDX_W-1:0]         crn_idx;
    logic signed [POS_W-1:0]   pc_comp [3];
    logic signed [NRM_W-1:0]   old_nrm [3];
    logic signed [EDGE_W-1:0]  mul_a, mul_b;
    logic [2:0]                acc_k;
    logic                      norm_start;
    logic signed [VEC_W-1:0]   norm_vec [3];
    logic                      norm_done;
    logic signed [NRM_W-1:0]   norm_res [3];

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign pos_we = accept && (opcode == OP_WRITE);

    always_comb
    begin
        case (crn_reg)
            2'd0:    crn_idx = a_reg;
            2'd1:    crn_idx = b_reg;
            default: crn_idx = c_reg;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_PA:   pos_raddr = a_reg;
            ST_PB:   pos_raddr = b_reg;
            default: pos_raddr = c_reg;
        endcase
    end

    // hold the read address over the capture cycle so the valid bit matches the data
    assign nrm_raddr = ((state_reg == ST_RD) || (state_reg == ST_RD_CAP)) ? a_reg : crn_idx;
    assign nrm_we    = (state_reg == ST_CRN_WAIT) && norm_done;
    assign nrm_wdata = {norm_res[2], norm_res[1], norm_res[0]};

    mvna_ram #(
        .WIDTH (POS_ENTRY_W),
        .DEPTH (VERTEX_DEPTH)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (VIDX_W'(corner_a)),
        .wdata ({pos_z, pos_y, pos_x}),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    mvna_ram #(
        .WIDTH (NRM_ENTRY_W),
        .DEPTH (VERTEX_DEPTH)
    ) u_nrm_ram (
        .clk   (clk),
        .we    (nrm_we),
        .waddr (crn_idx),
        .wdata (nrm_wdata),
        .raddr (nrm_raddr),
        .rdata (nrm_rdata)
    );

    // a never-filled or cleared vertex reads as a zero normal
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pc_comp[i] = $signed(pos_rdata[i*POS_W +: POS_W]);
            old_nrm[i] = nvalid_reg[nrm_raddr] ? $signed(nrm_rdata[i*NRM_W +: NRM_W]) : '0;
        end
    end

    always_comb
    begin
        case (kc_reg)
            3'd0:    begin mul_a = e1_reg[1]; mul_b = e2_reg[2]; end
            3'd1:    begin mul_a = e1_reg[2]; mul_b = e2_reg[1]; end
            3'd2:    begin mul_a = e1_reg[2]; mul_b = e2_reg[0]; end
            3'd3:    begin mul_a = e1_reg[0]; mul_b = e2_reg[2]; end
            3'd4:    begin mul_a = e1_reg[0]; mul_b = e2_reg[1]; end
            default: begin mul_a = e1_reg[1]; mul_b = e2_reg[0]; end
        endcase
    end

    assign acc_k = kc_reg - 3'd1;

    assign norm_start = (state_reg == ST_FACE_GO) || (state_reg == ST_CRN_GO);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (state_reg == ST_CRN_GO)
            begin
                norm_vec[i] = VEC_W'(old_nrm[i]) + VEC_W'(face_reg[i]);
            end
            else
            begin
                norm_vec[i] = cr_reg[i];
            end
        end
    end

    mvna_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vec   (norm_vec),
        .done  (norm_done),
        .res   (norm_res)
    );

    always_comb
    begin
        state_next = state_reg;
        kc_next    = kc_reg;
        crn_next   = crn_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_TRI:  state_next = ST_PA;
                        OP_READ: state_next = ST_RD;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD:        state_next = ST_RD_CAP;
            ST_RD_CAP:    state_next = ST_IDLE;
            ST_PA:        state_next = ST_PB;
            ST_PB:        state_next = ST_PC;
            ST_PC:        state_next = ST_PCAP;
            ST_PCAP:
            begin
                kc_next    = '0;
                state_next = ST_CROSS;
            end
            ST_CROSS:
            begin
                kc_next = kc_reg + 3'd1;
                if (kc_reg == 3'd6)
                begin
                    state_next = ST_FACE_GO;
                end
            end
            ST_FACE_GO:   state_next = ST_FACE_WAIT;
            ST_FACE_WAIT:
            begin
                if (norm_done)
                begin
                    crn_next   = '0;
                    state_next = ST_CRN_RD;
                end
            end
            ST_CRN_RD:    state_next = ST_CRN_GO;
            ST_CRN_GO:    state_next = ST_CRN_WAIT;
            ST_CRN_WAIT:
            begin
                if (norm_done)
                begin
                    crn_next   = crn_reg + 2'd1;
                    state_next = (crn_reg == 2'd2) ? ST_IDLE : ST_CRN_RD;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            kc_reg     <= '0;
            crn_reg    <= '0;
            for (int v = 0; v < VERTEX_DEPTH; v++)
            begin
                nvalid_reg[v] <= 1'b0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == ST_RD_CAP);
            kc_reg     <= kc_next;
            crn_reg    <= crn_next;
            if (pos_we)
            begin
                nvalid_reg[VIDX_W'(corner_a)] <= 1'b0;
            end
            else if (nrm_we)
            begin
                nvalid_reg[crn_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg <= VIDX_W'(corner_a);
            b_reg <= VIDX_W'(corner_b);
            c_reg <= VIDX_W'(corner_c);
        end
        if (state_reg == ST_PB)
        begin
            pa_reg <= pc_comp;
        end
        if (state_reg == ST_PC)
        begin
            pb_reg <= pc_comp;
        end
        if (state_reg == ST_PCAP)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= EDGE_W'(pb_reg[i]) - EDGE_W'(pa_reg[i]);
                e2_reg[i] <= EDGE_W'(pc_comp[i]) - EDGE_W'(pa_reg[i]);
            end
        end
        if (state_reg == ST_CROSS)
        begin
            prod_reg <= PROD_W'(mul_a * mul_b);
            // fold in the product of the previous step
            if (kc_reg != 3'd0)
            begin
                if (!acc_k[0])
                begin
                    cr_reg[acc_k[2:1]] <= VEC_W'(prod_reg);
                end
                else
                begin
                    cr_reg[acc_k[2:1]] <= cr_reg[acc_k[2:1]] - VEC_W'(prod_reg);
                end
            end
        end
        if ((state_reg == ST_FACE_WAIT) && norm_done)
        begin
            face_reg <= norm_res;
        end
        if (state_reg == ST_RD_CAP)
        begin
            read_index_reg <= IDX_W'(a_reg);
            out_reg        <= old_nrm;
        end
    end

    assign strobe     = strobe_reg;
    assign read_index = read_index_reg;
    assign norm_x     = out_reg[0];
    assign norm_y     = out_reg[1];
    assign norm_z     = out_reg[2];

    assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg == ST_RD_CAP))
        else $error("result strobe without a normal read");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_READ) |-> ##3 strobe_reg)
        else $error("normal read did not return in three cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        norm_done |-> (state_reg == ST_FACE_WAIT || state_reg == ST_CRN_WAIT))
        else $error("normalizer finished outside a wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        nrm_we |=> nvalid_reg[$past(crn_idx)])
        else $error("written normal not marked valid");

endmodule

@@ tb/sv/tb_mesh_vertex_normal_accumulator.sv @@
// Testbench for mesh_vertex_normal_accumulator: drives vertex writes, triangles, normal reads
// and spare opcodes, predicts every read result and checks it at the strobe.
// Depends on mvna_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_mesh_vertex_normal_accumulator;
    import mvna_pkg::*;

    typedef struct {
        logic [1:0]        op;
        logic [7:0]        a;
        logic [7:0]        b;
        logic [7:0]        c;
        logic signed [19:0] px;
        logic signed [19:0] py;
        logic signed [19:0] pz;
    } command_t;

    typedef struct {
        logic [7:0]         idx;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } normal_rd_t;

    localparam longint CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] opcode;
    logic [7:0] corner_a, corner_b, corner_c;
    logic signed [19:0] pos_x, pos_y, pos_z;
    logic strobe;
    logic [7:0] read_index;
    logic signed [15:0] norm_x, norm_y, norm_z;

    command_t   pending_cmds[$];
    normal_rd_t expected_reads[$];
    longint     vtx_pos[256][3];
    longint     vtx_nrm[256][3];
    bit         written[256];
    int         errors;
    longint     cycles;
    int         accepted;
    int         queued;
    bit         quiet_stretch;

    mesh_vertex_normal_accumulator u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .corner_a(corner_a), .corner_b(corner_b),
        .corner_c(corner_c), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .strobe(strobe), .read_index(read_index),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= r + bitv)
            begin
                x -= r + bitv;
                r = (r >> 1) + bitv;
            end
            else
                r >>= 1;
            bitv >>= 2;
        end
        return r;
    endfunction

    task automatic unit_vector(input longint v[3], output longint o[3]);
        longint unsigned mag[3];
        longint unsigned m, len2, r, n;
        m = 0;
        len2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (v[i] < 0) ? -v[i] : v[i];
            if (mag[i] > m)
                m = mag[i];
        end
        if (m == 0)
        begin
            o[0] = 0; o[1] = 0; o[2] = 0;
            return;
        end
        while (m >= (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++)
                mag[i] >>= 1;
            m >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
            m <<= 1;
        end
        for (int i = 0; i < 3; i++)
            len2 += mag[i] * mag[i];
        r = int_sqrt(len2);
        for (int i = 0; i < 3; i++)
        begin
            n = (mag[i] * 16384 + (r >> 1)) / r;
            o[i] = (v[i] < 0) ? -longint'(n) : longint'(n);
        end
    endtask

    task automatic predict_command(input command_t cmd);
        longint e1[3], e2[3], cr[3], face[3], sum[3], res[3];
        logic [7:0] crn[3];
        normal_rd_t rd;
        case (cmd.op)
            OP_WRITE:
            begin
                vtx_pos[cmd.a][0] = cmd.px;
                vtx_pos[cmd.a][1] = cmd.py;
                vtx_pos[cmd.a][2] = cmd.pz;
                for (int i = 0; i < 3; i++)
                    vtx_nrm[cmd.a][i] = 0;
            end
            OP_TRI:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1[i] = vtx_pos[cmd.b][i] - vtx_pos[cmd.a][i];
                    e2[i] = vtx_pos[cmd.c][i] - vtx_pos[cmd.a][i];
                end
                cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
                cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
                cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
                unit_vector(cr, face);
                crn[0] = cmd.a; crn[1] = cmd.b; crn[2] = cmd.c;
                for (int k = 0; k < 3; k++)
                begin
                    for (int i = 0; i < 3; i++)
                        sum[i] = vtx_nrm[crn[k]][i] + face[i];
                    unit_vector(sum, res);
                    for (int i = 0; i < 3; i++)
                        vtx_nrm[crn[k]][i] = res[i];
                end
            end
            OP_READ:
            begin
                rd.idx = cmd.a;
                rd.nx = 16'(vtx_nrm[cmd.a][0]);
                rd.ny = 16'(vtx_nrm[cmd.a][1]);
                rd.nz = 16'(vtx_nrm[cmd.a][2]);
                expected_reads.push_back(rd);
            end
            default: ;
        endcase
    endtask

    function automatic logic [7:0] pick_written();
        logic [7:0] v;
        do
            v = 8'($urandom_range(255));
        while (!written[v]);
        return v;
    endfunction

    function automatic logic signed [19:0] rand_pos();
        case ($urandom_range(5))
            0: return -20'sd524288;
            1: return 20'sd524287;
            2: return 20'($urandom_range(2047) - 1024);
            default: return 20'($urandom);
        endcase
    endfunction

    task automatic queue_cmd(input logic [1:0] op, input logic [7:0] a, b, c,
                             input logic signed [19:0] x, y, z);
        command_t cmd;
        cmd.op = op; cmd.a = a; cmd.b = b; cmd.c = c;
        cmd.px = x; cmd.py = y; cmd.pz = z;
        if (op == OP_WRITE)
            written[a] = 1'b1;
        pending_cmds.push_back(cmd);
        queued++;
    endtask

    // driver: hold the command until accepted, advance on start & !busy
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_command(pending_cmds.pop_front());
                accepted++;
            end
            if (!(start && busy))
            begin
                if (pending_cmds.size() > 0 && (quiet_stretch || $urandom_range(99) >= 36))
                begin
                    start    <= 1'b1;
                    opcode   <= pending_cmds[0].op;
                    corner_a <= pending_cmds[0].a;
                    corner_b <= pending_cmds[0].b;
                    corner_c <= pending_cmds[0].c;
                    pos_x    <= pending_cmds[0].px;
                    pos_y    <= pending_cmds[0].py;
                    pos_z    <= pending_cmds[0].pz;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: compare each read transaction with the oldest expected normal
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && strobe)
        begin
            if (expected_reads.size() == 0)
            begin
                $display("%0t: unexpected read idx=%0d n=(%0d,%0d,%0d)", $time,
                         read_index, norm_x, norm_y, norm_z);
                errors++;
            end
            else
            begin
                normal_rd_t exp_rd;
                exp_rd = expected_reads.pop_front();
                if (read_index !== exp_rd.idx || norm_x !== exp_rd.nx ||
                    norm_y !== exp_rd.ny || norm_z !== exp_rd.nz)
                begin
                    $display({"%0t: mismatch expected idx=%0d n=(%0d,%0d,%0d)",
                              " actual idx=%0d n=(%0d,%0d,%0d)"},
                             $time, exp_rd.idx, exp_rd.nx, exp_rd.ny, exp_rd.nz,
                             read_index, norm_x, norm_y, norm_z);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        logic [7:0] a, b, c;
        int r;
        errors = 0;
        cycles = 0;
        accepted = 0;
        queued = 0;
        quiet_stretch = 1'b0;
        start = 1'b0;
        opcode = '0;
        corner_a = '0; corner_b = '0; corner_c = '0;
        pos_x = '0; pos_y = '0; pos_z = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, degenerate and repeated corners, ignored opcode
        queue_cmd(OP_WRITE, 8'd0, 8'd0, 8'd0, 20'sd0, 20'sd0, 20'sd0);
        queue_cmd(OP_WRITE, 8'd255, 8'd0, 8'd0, 20'sd524287, -20'sd524288, 20'sd524287);
        queue_cmd(OP_WRITE, 8'd1, 8'd0, 8'd0, 20'sd1024, 20'sd0, 20'sd0);
        queue_cmd(OP_WRITE, 8'd2, 8'd0, 8'd0, 20'sd0, 20'sd1024, 20'sd0);
        queue_cmd(OP_WRITE, 8'd3, 8'd0, 8'd0, -20'sd524288, 20'sd524287, -20'sd524288);
        queue_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 20'sd0, 20'sd0, 20'sd0);
        queue_cmd(OP_TRI, 8'd0, 8'd1, 8'd2, 20'sd0, 20'sd0, 20'sd0);
        queue_cmd(OP_READ, 8'd2, 8'd0, 8'd0, 20'sd0, 20'sd0, 20'sd0);
        queue_cmd(OP_TRI, 8'd0, 8'd255, 8'd3, 20'sd0, 20'sd0, 20'sd0);
        queue_cmd(OP_TRI, 8'd1, 8'd1, 8'd1, 20'sd0, 20'sd0, 20'sd0);
        queue_cmd(OP_TRI, 8'd255, 8'd255, 8'd3, 20'sd0, 20'sd0, 20'sd0);
        queue_cmd(OP_READ, 8'd255, 8'd0, 8'd0, 20'sd0, 20'sd0, 20'sd0);
        queue_cmd(OP_READ, 8'd3, 8'd0, 8'd0, 20'sd0, 20'sd0, 20'sd0);
        queue_cmd(OP_SPARE, 8'd255, 8'd255, 8'd255, -20'sd1, -20'sd1, -20'sd1);
        queue_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 20'sd0, 20'sd0, 20'sd0);
        queue_cmd(OP_WRITE, 8'd0, 8'd0, 8'd0, 20'sd5, 20'sd7, -20'sd3);
        queue_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 20'sd0, 20'sd0, 20'sd0);
        queue_cmd(OP_READ, 8'd1, 8'd0, 8'd0, 20'sd0, 20'sd0, 20'sd0);

        // random: triangles on written vertices, writes and reads mixed, rarely a spare opcode
        for (int i = 0; i < 1000; i++)
        begin
            r = $urandom_range(99);
            if (r < 25)
                queue_cmd(OP_WRITE, 8'($urandom), 8'($urandom), 8'($urandom),
                          rand_pos(), rand_pos(), rand_pos());
            else if (r < 60)
            begin
                a = pick_written();
                b = pick_written();
                c = ($urandom_range(9) == 0) ? a : pick_written();
                queue_cmd(OP_TRI, a, b, c, 20'($urandom), 20'($urandom), 20'($urandom));
            end
            else if (r < 97)
                queue_cmd(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                          20'($urandom), 20'($urandom), 20'($urandom));
            else
                queue_cmd(OP_SPARE, 8'($urandom), 8'($urandom), 8'($urandom),
                          20'($urandom), 20'($urandom), 20'($urandom));
        end

        fork
            begin
                while (accepted < queued / 3)
                    @(posedge clk);
                quiet_stretch = 1'b1;
                while (accepted < queued / 2)
                    @(posedge clk);
                quiet_stretch = 1'b0;
            end
        join_none

        while ((accepted < queued || start || busy || expected_reads.size() > 0)
               && cycles < CYCLE_LIMIT)
            @(posedge clk);
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            repeat (10) @(posedge clk);
            if (errors == 0 && expected_reads.size() == 0)
                $display("DONE: 0 errors");
            else
                $display("DONE: errors detected");
            $finish;
        end
    end
endmodule
